### design/ibe_pkg.sv
// Package of the block evaluator: sizes, item and result types, codes and
// the control bundles passed between the front, back and result queue.
// No dependencies.
package ibe_pkg;

    localparam int NUM_REGS  = 32;
    localparam int REG_WIDTH = 64;
    localparam int ADDR_W    = $clog2(NUM_REGS);
    localparam int FQ_DEPTH  = 2;
    localparam int FQ_AW     = $clog2(FQ_DEPTH);
    localparam int FQ_CW     = $clog2(FQ_DEPTH + 1);
    localparam int RQ_DEPTH  = 2;
    localparam int RQ_AW     = $clog2(RQ_DEPTH);
    localparam int RQ_CW     = $clog2(RQ_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_EXEC  = 2'd2,
        CMD_DUMP  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OP_WIMM = 3'd0,
        OP_ADDI = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_FALL = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DREAD,
        S_DPUSH
    } t_state;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [4:0]         reg_index;
        logic [63:0]        load_value;
        logic [2:0]         opcode;
        logic [4:0]         rd;
        logic [4:0]         rs1;
        logic [4:0]         rs2;
        logic signed [63:0] imm;
        logic [63:0]        instr_next_pc;
        logic               unit_ok;
        logic [7:0]         reject_code;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  reg_number;
        logic [63:0] reg_value;
        logic [63:0] final_pc;
        logic [15:0] retired_count;
        logic        ok;
        logic [7:0]  reject_out;
        logic        last;
    } t_out_item;

    typedef struct packed {
        t_cmd        kind;
        t_op         op;
        logic [4:0]  idx;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [63:0] data;
        logic [63:0] imm;
        logic [63:0] npc;
        logic        ok;
        logic [7:0]  rej;
    } t_work;

    typedef struct packed {
        logic  valid;
        t_work item;
    } t_work_head;

    typedef struct packed {
        logic      valid;
        t_out_item data;
    } t_res_push;

    function automatic logic idx_in_range(input logic [4:0] idx);
        return {2'b00, idx} < 7'(NUM_REGS);
    endfunction

endpackage

### design/ibe_front.sv
// Front end of the block evaluator: accepts input beats, classifies them into
// work entries and holds them in a short queue. Depends on ibe_pkg.
module ibe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ibe_pkg::t_in_item i_item,
    output logic              o_full,
    output ibe_pkg::t_work_head o_head,
    input  logic              i_pop
);
    import ibe_pkg::*;

    t_work            r_q [FQ_DEPTH];
    logic [FQ_AW-1:0] r_wp, n_wp;
    logic [FQ_AW-1:0] r_rp, n_rp;
    logic [FQ_CW-1:0] r_cnt, n_cnt;
    t_work            w_item;
    logic             w_keep;
    logic             w_enq;
    logic             w_deq;

    always_comb begin
        w_item.kind = t_cmd'(i_item.cmd);
        w_item.op   = OP_FALL;
        w_item.idx  = (t_cmd'(i_item.cmd) == CMD_LOAD) ? i_item.reg_index : i_item.rd;
        w_item.rs1  = i_item.rs1;
        w_item.rs2  = i_item.rs2;
        w_item.data = i_item.load_value;
        w_item.imm  = i_item.imm;
        w_item.npc  = i_item.instr_next_pc;
        w_item.ok   = i_item.unit_ok;
        w_item.rej  = i_item.reject_code;
        w_keep      = 1'b1;
        if (t_cmd'(i_item.cmd) == CMD_EXEC) begin
            unique case (i_item.opcode)
                OP_WIMM: w_item.op = OP_WIMM;
                OP_ADDI: w_item.op = OP_ADDI;
                OP_ADD:  w_item.op = OP_ADD;
                OP_SUB:  w_item.op = OP_SUB;
                OP_FALL: w_item.op = OP_FALL;
                default: w_keep = 1'b0;
            endcase
        end
    end

    assign o_full = (r_cnt == FQ_CW'(FQ_DEPTH));
    assign w_enq  = i_push && !o_full && w_keep;
    assign w_deq  = i_pop && (r_cnt != '0);

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_q[r_rp];

    always_comb begin
        n_wp  = w_enq ? FQ_AW'(r_wp + 1'b1) : r_wp;
        n_rp  = w_deq ? FQ_AW'(r_rp + 1'b1) : r_rp;
        n_cnt = FQ_CW'(r_cnt + FQ_CW'(w_enq) - FQ_CW'(w_deq));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule

### design/ibe_resq.sv
// Result queue of the block evaluator: holds dump results until the consumer
// takes them. Depends on ibe_pkg.
module ibe_resq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ibe_pkg::t_res_push i_push,
    output logic               o_full,
    output logic               o_empty,
    input  logic               i_pop,
    output ibe_pkg::t_out_item o_data
);
    import ibe_pkg::*;

    t_out_item        r_q [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wp;
    logic [RQ_AW-1:0] r_rp;
    logic [RQ_CW-1:0] r_cnt;
    logic             w_enq;
    logic             w_deq;

    assign o_full  = (r_cnt == RQ_CW'(RQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_q[r_rp];
    assign w_enq   = i_push.valid && !o_full;
    assign w_deq   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_enq) begin
                r_wp <= RQ_AW'(r_wp + 1'b1);
            end
            if (w_deq) begin
                r_rp <= RQ_AW'(r_rp + 1'b1);
            end
            r_cnt <= RQ_CW'(r_cnt + RQ_CW'(w_enq) - RQ_CW'(w_deq));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_q[r_wp] <= i_push.data;
        end
    end

endmodule

### design/ibe_back.sv
// Back end of the block evaluator: sequencer that runs work entries against
// the register file memory and walks it for the dump. Depends on ibe_pkg.
module ibe_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ibe_pkg::t_work_head i_head,
    output logic                o_pop,
    output ibe_pkg::t_res_push  o_res,
    input  logic                i_res_full
);
    import ibe_pkg::*;

    logic [REG_WIDTH-1:0] r_mem [NUM_REGS];
    logic [REG_WIDTH-1:0] r_rd1;
    logic [REG_WIDTH-1:0] r_rd2;
    logic [ADDR_W-1:0]    w_ra1;
    logic [ADDR_W-1:0]    w_ra2;
    logic                 w_we;
    logic [ADDR_W-1:0]    w_wa;
    logic [REG_WIDTH-1:0] w_wd;

    t_state               r_state, n_state;
    logic [63:0]          r_pc, n_pc;
    logic [15:0]          r_cnt, n_cnt;
    logic                 r_valid, n_valid;
    logic [7:0]           r_rej, n_rej;
    logic [ADDR_W-1:0]    r_idx, n_idx;

    t_op                  r_op, n_op;
    logic [4:0]           r_rd, n_rd;
    logic                 r_z1, n_z1;
    logic                 r_z2, n_z2;
    logic [REG_WIDTH-1:0] r_imm, n_imm;
    logic [63:0]          r_npc, n_npc;

    logic [REG_WIDTH-1:0] w_s1;
    logic [REG_WIDTH-1:0] w_s2;
    logic [REG_WIDTH-1:0] w_sum;
    logic                 w_last;

    assign w_s1   = r_z1 ? '0 : r_rd1;
    assign w_s2   = r_z2 ? '0 : r_rd2;
    assign w_last = (r_idx == ADDR_W'(NUM_REGS - 1));

    always_comb begin
        unique case (r_op)
            OP_WIMM: w_sum = r_imm;
            OP_ADDI: w_sum = w_s1 + r_imm;
            OP_ADD:  w_sum = w_s1 + w_s2;
            OP_SUB:  w_sum = w_s1 - w_s2;
            OP_FALL: w_sum = w_s1;
            default: w_sum = w_s1;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_cnt   = r_cnt;
        n_valid = r_valid;
        n_rej   = r_rej;
        n_idx   = r_idx;
        n_op    = r_op;
        n_rd    = r_rd;
        n_z1    = r_z1;
        n_z2    = r_z2;
        n_imm   = r_imm;
        n_npc   = r_npc;
        o_pop   = 1'b0;
        w_ra1   = r_idx;
        w_ra2   = r_idx;
        w_we    = 1'b0;
        w_wa    = ADDR_W'(i_head.item.idx);
        w_wd    = REG_WIDTH'(i_head.item.data);

        o_res.valid              = 1'b0;
        o_res.data.reg_number    = 5'(r_idx);
        o_res.data.reg_value     = 64'(((r_idx == '0) && r_valid) ? '0 : r_rd1);
        o_res.data.final_pc      = r_pc;
        o_res.data.retired_count = r_cnt;
        o_res.data.ok            = r_valid;
        o_res.data.reject_out    = r_valid ? 8'd0 : r_rej;
        o_res.data.last          = w_last;

        unique case (r_state)
            S_IDLE: begin
                w_ra1 = ADDR_W'(i_head.item.rs1);
                w_ra2 = ADDR_W'(i_head.item.rs2);
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    unique case (i_head.item.kind)
                        CMD_BEGIN: begin
                            n_pc    = i_head.item.data;
                            n_cnt   = '0;
                            n_valid = i_head.item.ok;
                            n_rej   = i_head.item.rej;
                        end
                        CMD_LOAD: begin
                            w_we = idx_in_range(i_head.item.idx);
                        end
                        CMD_EXEC: begin
                            if (r_valid) begin
                                n_op    = i_head.item.op;
                                n_rd    = i_head.item.idx;
                                n_z1    = (i_head.item.rs1 == '0)
                                          || !idx_in_range(i_head.item.rs1);
                                n_z2    = (i_head.item.rs2 == '0)
                                          || !idx_in_range(i_head.item.rs2);
                                n_imm   = REG_WIDTH'(i_head.item.imm);
                                n_npc   = i_head.item.npc;
                                n_state = S_EXEC;
                            end
                        end
                        CMD_DUMP: begin
                            n_idx   = '0;
                            n_state = S_DREAD;
                        end
                        default: ;
                    endcase
                end
            end
            S_EXEC: begin
                w_wa    = ADDR_W'(r_rd);
                w_wd    = w_sum;
                w_we    = (r_op != OP_FALL) && (r_rd != '0) && idx_in_range(r_rd);
                n_pc    = r_npc;
                if ((r_op != OP_FALL) && (r_cnt != 16'hFFFF)) begin
                    n_cnt = r_cnt + 16'd1;
                end
                n_state = S_IDLE;
            end
            S_DREAD: begin
                n_state = S_DPUSH;
            end
            S_DPUSH: begin
                if (!i_res_full) begin
                    o_res.valid = 1'b1;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = ADDR_W'(r_idx + 1'b1);
                        n_state = S_DREAD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
            r_rej   <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
            r_rej   <= n_rej;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_op  <= n_op;
        r_rd  <= n_rd;
        r_z1  <= n_z1;
        r_z2  <= n_z2;
        r_imm <= n_imm;
        r_npc <= n_npc;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd1 <= r_mem[w_ra1];
        r_rd2 <= r_mem[w_ra2];
    end

endmodule

### design/ir_block_evaluator.sv
// Top level of the block evaluator: front queue, back sequencer with the
// register file, and result queue. Depends on ibe_pkg, ibe_front, ibe_back, ibe_resq.
//
// A begin or load beat retires in the idle state of the back sequencer. An
// execute beat of an accepted unit first reads both source registers from the
// register file memory, then computes the result and writes it back; in a
// rejected unit it is popped in the idle state without executing. A dump beat
// walks the register file one register at a time, reading it and then pushing
// it, and stalls while the two-entry result queue is full. A two-entry queue in
// front lets new beats arrive while the sequencer is busy; execute beats with an
// undefined opcode are dropped at the front and cost nothing.
module ir_block_evaluator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  ibe_pkg::t_in_item  i_item,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output ibe_pkg::t_out_item o_result
);
    import ibe_pkg::*;

    t_work_head w_head;
    logic       w_pop;
    t_res_push  w_res;
    logic       w_res_full;

    ibe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    ibe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_res      (w_res),
        .i_res_full (w_res_full)
    );

    ibe_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res),
        .o_full  (w_res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (o_result)
    );

endmodule

### tb/tb_top.sv
// Testbench of ir_block_evaluator: a table of directed beats, then random units and single
// random beats, all checked against an in-bench predictor.
// Depends on ibe_pkg and the ir_block_evaluator top level.
module tb_top;
    import ibe_pkg::*;

    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_BEATS  = 140;
    localparam int PRINT_LIMIT   = 40;
    localparam logic [2:0]  OP_RSVD_LO = 3'd5;
    localparam logic [2:0]  OP_RSVD_HI = 3'd7;
    localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN_NEG    = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_POS    = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        t_in_item  beat;
        bit        typed;
        t_out_item want;
    } t_step;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_item  i_item  = '0;
    logic      full;
    logic      empty;
    t_out_item o_result;

    logic [63:0] shadow_regs [NUM_REGS];
    logic [63:0] shadow_pc    = '0;
    logic [15:0] shadow_count = '0;
    logic        shadow_ok    = 1'b0;
    logic [7:0]  shadow_rej   = '0;

    t_out_item dump_expect [$];
    t_step     plan [$];
    bit        steady       = 1'b0;
    int        mismatches   = 0;
    int        beats_sent   = 0;
    int        dumps_sent   = 0;
    int        results_seen = 0;
    int        quiet_cycles = 0;

    ir_block_evaluator uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #2 i_clk = ~i_clk;

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    function automatic logic [63:0] shadow_read(input logic [4:0] idx);
        if (idx == '0 && shadow_ok) begin
            return '0;
        end
        return shadow_regs[idx];
    endfunction

    // Updates the shadow state for one accepted beat and queues the dump it causes.
    function automatic void evaluate_beat(input t_in_item b);
        logic [63:0] sum;
        t_out_item   r;
        sum = '0;
        case (t_cmd'(b.cmd))
            CMD_BEGIN: begin
                shadow_pc    = b.load_value;
                shadow_count = '0;
                shadow_ok    = b.unit_ok;
                shadow_rej   = b.reject_code;
            end
            CMD_LOAD: begin
                shadow_regs[b.reg_index] = b.load_value;
            end
            CMD_EXEC: begin
                if (shadow_ok && b.opcode <= OP_FALL) begin
                    case (b.opcode)
                        OP_WIMM: sum = b.imm;
                        OP_ADDI: sum = shadow_read(b.rs1) + b.imm;
                        OP_ADD:  sum = shadow_read(b.rs1) + shadow_read(b.rs2);
                        OP_SUB:  sum = shadow_read(b.rs1) - shadow_read(b.rs2);
                        default: sum = '0;
                    endcase
                    if (b.opcode != OP_FALL) begin
                        if (b.rd != '0) begin
                            shadow_regs[b.rd] = sum;
                        end
                        if (shadow_count != 16'hFFFF) begin
                            shadow_count++;
                        end
                    end
                    shadow_pc = b.instr_next_pc;
                end
            end
            default: begin
                for (int n = 0; n < NUM_REGS; n++) begin
                    r.reg_number    = 5'(n);
                    r.reg_value     = shadow_read(5'(n));
                    r.final_pc      = shadow_pc;
                    r.retired_count = shadow_count;
                    r.ok            = shadow_ok;
                    r.reject_out    = shadow_ok ? 8'h00 : shadow_rej;
                    r.last          = (n == NUM_REGS - 1);
                    dump_expect.push_back(r);
                end
            end
        endcase
    endfunction

    task automatic check_result(input t_out_item got);
        t_out_item want;
        results_seen++;
        if (dump_expect.size() == 0) begin
            flag_mismatch($sformatf("result beat for register %0d with none expected",
                                    got.reg_number));
            return;
        end
        want = dump_expect.pop_front();
        if (got.reg_number !== want.reg_number) begin
            flag_mismatch($sformatf("reg_number got %0d want %0d",
                                    got.reg_number, want.reg_number));
        end
        if (got.reg_value !== want.reg_value) begin
            flag_mismatch($sformatf("reg %0d reg_value got %h want %h",
                                    want.reg_number, got.reg_value, want.reg_value));
        end
        if (got.final_pc !== want.final_pc) begin
            flag_mismatch($sformatf("reg %0d final_pc got %h want %h",
                                    want.reg_number, got.final_pc, want.final_pc));
        end
        if (got.retired_count !== want.retired_count) begin
            flag_mismatch($sformatf("reg %0d retired_count got %0d want %0d",
                                    want.reg_number, got.retired_count, want.retired_count));
        end
        if (got.ok !== want.ok) begin
            flag_mismatch($sformatf("reg %0d ok got %b want %b",
                                    want.reg_number, got.ok, want.ok));
        end
        if (got.reject_out !== want.reject_out) begin
            flag_mismatch($sformatf("reg %0d reject_out got %h want %h",
                                    want.reg_number, got.reject_out, want.reject_out));
        end
        if (got.last !== want.last) begin
            flag_mismatch($sformatf("reg %0d last got %b want %b",
                                    want.reg_number, got.last, want.last));
        end
    endtask

    function automatic logic [63:0] pick_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return MIN_NEG;
            3:       return MAX_POS;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_in_item rand_beat(input t_cmd kind);
        t_in_item b;
        b.cmd           = kind;
        b.reg_index     = 5'($urandom_range(NUM_REGS - 1));
        b.load_value    = pick_word();
        b.opcode        = ($urandom_range(99) < 88) ? 3'($urandom_range(OP_FALL))
                                                    : 3'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
        b.rd            = 5'($urandom);
        b.rs1           = 5'($urandom);
        b.rs2           = 5'($urandom);
        b.imm           = pick_word();
        b.instr_next_pc = pick_word();
        b.unit_ok       = ($urandom_range(99) < 85);
        b.reject_code   = 8'($urandom);
        return b;
    endfunction

    function automatic t_in_item mk_begin(input logic [63:0] pc, input logic ok,
                                          input logic [7:0] rej);
        t_in_item b;
        b             = '0;
        b.cmd         = CMD_BEGIN;
        b.load_value  = pc;
        b.unit_ok     = ok;
        b.reject_code = rej;
        return b;
    endfunction

    function automatic t_in_item mk_load(input logic [4:0] idx, input logic [63:0] value);
        t_in_item b;
        b            = '0;
        b.cmd        = CMD_LOAD;
        b.reg_index  = idx;
        b.load_value = value;
        return b;
    endfunction

    function automatic t_in_item mk_exec(input logic [2:0] op, input logic [4:0] rd,
                                         input logic [4:0] rs1, input logic [4:0] rs2,
                                         input logic [63:0] imm, input logic [63:0] npc);
        t_in_item b;
        b               = '0;
        b.cmd           = CMD_EXEC;
        b.opcode        = op;
        b.rd            = rd;
        b.rs1           = rs1;
        b.rs2           = rs2;
        b.imm           = imm;
        b.instr_next_pc = npc;
        return b;
    endfunction

    function automatic t_in_item mk_dump();
        t_in_item b;
        b     = '0;
        b.cmd = CMD_DUMP;
        return b;
    endfunction

    function automatic t_out_item summary(input logic [63:0] pc, input logic [15:0] count,
                                          input logic ok, input logic [7:0] rej);
        t_out_item w;
        w               = '0;
        w.final_pc      = pc;
        w.retired_count = count;
        w.ok            = ok;
        w.reject_out    = rej;
        return w;
    endfunction

    function automatic t_step step(input t_in_item b, input bit typed = 1'b0,
                                   input t_out_item w = '0);
        t_step s;
        s.beat  = b;
        s.typed = typed;
        s.want  = w;
        return s;
    endfunction

    // Drives one beat and waits for it to be taken. A typed step replaces the
    // predicted pc, count, ok and reject fields of its dump with fixed values.
    task automatic send_beat(input t_in_item b, input bit typed = 1'b0,
                             input t_out_item w = '0);
        int first;
        while (!steady && $urandom_range(99) < 28) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= b;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        first = dump_expect.size();
        evaluate_beat(b);
        if (typed) begin
            for (int k = first; k < dump_expect.size(); k++) begin
                dump_expect[k].final_pc      = w.final_pc;
                dump_expect[k].retired_count = w.retired_count;
                dump_expect[k].ok            = w.ok;
                dump_expect[k].reject_out    = w.reject_out;
            end
        end
        beats_sent++;
        if (t_cmd'(b.cmd) == CMD_DUMP) begin
            dumps_sent++;
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (dump_expect.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_random_unit();
        int n_load;
        int n_exec;
        n_load = $urandom_range(3);
        n_exec = $urandom_range(12, 1);
        send_beat(rand_beat(CMD_BEGIN));
        repeat (n_load) send_beat(rand_beat(CMD_LOAD));
        repeat (n_exec) send_beat(rand_beat(CMD_EXEC));
        send_beat(rand_beat(CMD_DUMP));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            check_result(o_result);
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (steady) begin
            pop <= 1'b1;
        end else begin
            pop <= ($urandom_range(99) >= 28);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("stall: no beat moved for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int stop_at;

        plan.push_back(step(mk_dump(), 1'b1, summary('0, '0, 1'b0, 8'h00)));
        plan.push_back(step(mk_begin(ALL_ONES, 1'b0, 8'hFF)));
        plan.push_back(step(mk_exec(OP_ADD, 5'd9, 5'd31, 5'd31, '0, 64'h10)));
        plan.push_back(step(mk_dump(), 1'b1, summary(ALL_ONES, '0, 1'b0, 8'hFF)));
        plan.push_back(step(mk_begin(64'h1000, 1'b1, 8'hA5)));
        plan.push_back(step(mk_load(5'd31, ALL_ONES)));
        plan.push_back(step(mk_load(5'd1, 64'd1)));
        plan.push_back(step(mk_exec(OP_WIMM, 5'd0, 5'd0, 5'd0, ALL_ONES, 64'h1004)));
        plan.push_back(step(mk_exec(OP_WIMM, 5'd2, 5'd0, 5'd0, MIN_NEG, 64'h1008)));
        plan.push_back(step(mk_exec(OP_ADDI, 5'd3, 5'd31, 5'd0, 64'd1, 64'h100C)));
        plan.push_back(step(mk_exec(OP_ADD, 5'd4, 5'd31, 5'd31, MAX_POS, 64'h1010)));
        plan.push_back(step(mk_exec(OP_SUB, 5'd5, 5'd0, 5'd1, '0, 64'h1014)));
        plan.push_back(step(mk_exec(OP_FALL, 5'd6, 5'd1, 5'd1, '0, 64'hFFFF_FFFF_FFFF_FFF0)));
        plan.push_back(step(mk_exec(OP_RSVD_HI, 5'd7, 5'd1, 5'd1, ALL_ONES, 64'h2000)));
        plan.push_back(step(mk_exec(OP_RSVD_LO, 5'd8, 5'd1, 5'd1, ALL_ONES, 64'h2004)));
        plan.push_back(step(mk_dump(), 1'b1,
                            summary(64'hFFFF_FFFF_FFFF_FFF0, 16'd5, 1'b1, 8'h00)));
        plan.push_back(step(mk_load(5'd0, 64'hDEAD_BEEF_0123_4567)));
        plan.push_back(step(mk_exec(OP_ADD, 5'd6, 5'd0, 5'd0, '0, 64'h3000)));
        plan.push_back(step(mk_dump()));
        plan.push_back(step(mk_begin(64'h2000, 1'b0, 8'h00)));
        plan.push_back(step(mk_dump(), 1'b1, summary(64'h2000, '0, 1'b0, 8'h00)));
        plan.push_back(step(mk_begin('0, 1'b1, 8'h00)));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every register is written once up front so that no dump reads an unwritten entry.
        for (int r = 0; r < NUM_REGS; r++) begin
            send_beat(mk_load(5'(r), (r == 0) ? ALL_ONES : (r == 1) ? 64'd0 : pick_word()));
        end

        foreach (plan[k]) begin
            send_beat(plan[k].beat, plan[k].typed, plan[k].want);
        end
        wait_drained();

        stop_at = beats_sent + RANDOM_BEATS;
        steady <= 1'b1;
        while (beats_sent < stop_at) begin
            if (beats_sent > stop_at - RANDOM_BEATS + 60) begin
                steady <= 1'b0;
            end
            if ($urandom_range(99) < 85) begin
                run_random_unit();
            end else begin
                send_beat(rand_beat(t_cmd'($urandom_range(3))));
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d beats in, %0d dumps and %0d result beats checked",
                 beats_sent, dumps_sent, results_seen);
        $display("including rejected units, undefined opcodes, register zero and wrapping sums");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
